FILE: rtl/pidl_pkg.sv
// Shared types and constants for the positional insert/delete list unit.
// No dependencies.
package pidl_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int IDX_W     = 9;   // holds any cell index or count up to 256
    localparam int CAP_W     = 5;
    localparam int POS_W     = 5;
    localparam int DATA_W    = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
    localparam logic [DATA_W-1:0] NO_DATA   = '1;

    localparam logic [2:0] MODE_APPEND     = 3'd0;
    localparam logic [2:0] MODE_INSERT     = 3'd1;
    localparam logic [2:0] MODE_REMOVE_END = 3'd2;
    localparam logic [2:0] MODE_REMOVE_POS = 3'd3;
    localparam logic [2:0] MODE_READ       = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic [IDX_W-1:0]         where;
        logic [DATA_W-1:0]        value;
    } cell_ctl_t;

    typedef struct packed {
        logic [2:0]               mode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] data;
        logic [CAP_W-1:0]         count;
        logic                     empty_res;
        logic                     full_res;
    } res_t;

endpackage

FILE: rtl/pidl_cell.sv
// One list slot: holds an entry and takes from its neighbors on shifts.
// Depends on pidl_pkg.
module pidl_cell #(
    parameter int IDX = 0
) (
    input  logic                            clk,
    input  pidl_pkg::cell_ctl_t             ctl,
    input  logic [pidl_pkg::DATA_W-1:0]     prev_data,
    input  logic [pidl_pkg::DATA_W-1:0]     next_data,
    output logic [pidl_pkg::DATA_W-1:0]     data
);
    import pidl_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (MY_IDX == ctl.where)
                    data_next = ctl.value;
                else if (MY_IDX > ctl.where)
                    data_next = prev_data;
            end
            CELL_REMOVE:
            begin
                if (MY_IDX >= ctl.where)
                    data_next = next_data;
            end
            default:
                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: rtl/positional_insert_delete_list_unit.sv
// Positional insert/delete list: a row of DEPTH cells shifting in place.
// done rises in the cycle after an accepted start; one request per cycle, busy stays low.
// Shifts happen across all cells in the accept cycle; the read select is one mux.
// Reset clears count to 0 and capacity to 16; cell contents are undefined until written.
// Results cannot be stalled: each beat is on res for the single cycle done is high.
// Depends on pidl_pkg and pidl_cell.
module positional_insert_delete_list_unit #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  pidl_pkg::req_t              req,
    output logic                        done,
    output pidl_pkg::res_t              res,
    input  logic                        cfg_we,
    input  logic [pidl_pkg::CAP_W-1:0]  cfg_data
);
    import pidl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int PW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [PW-1:0] DEPTH_X = PW'(DEPTH);

    logic [CAP_W-1:0]  capacity_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              done_reg;
    res_t              res_reg;
    res_t              res_next;

    logic [DATA_W-1:0] cell_q [DEPTH];
    cell_ctl_t         ctl;

    logic [PW-1:0]     cap_x;
    logic [PW-1:0]     cnt_x;
    logic [PW-1:0]     pos_x;
    logic [PW-1:0]     eff_cap;
    logic [PW-1:0]     sel_x;
    logic [PW-1:0]     cnt_new_x;
    logic              full_now;
    logic [DATA_W-1:0] rd_data;
    logic              accept;

    assign accept = start && !busy;
    assign busy   = 1'b0;

    assign cap_x   = PW'(capacity_reg);
    assign cnt_x   = PW'(count_reg);
    assign pos_x   = PW'(req.position);
    assign eff_cap = (cap_x > DEPTH_X) ? DEPTH_X : cap_x;
    assign full_now = cnt_x >= eff_cap;

    assign sel_x   = (req.mode == MODE_REMOVE_END) ? (cnt_x - PW'(1)) : pos_x;
    assign rd_data = cell_q[sel_x[AW-1:0]];

    always_comb
    begin
        ctl.op      = CELL_HOLD;
        ctl.where   = IDX_W'(pos_x);
        ctl.value   = req.value;
        count_next  = count_reg;
        res_next.ok   = 1'b0;
        res_next.data = NO_DATA;
        case (req.mode)
            MODE_APPEND:
            begin
                if (!full_now)
                begin
                    ctl.op      = CELL_INSERT;
                    ctl.where   = IDX_W'(cnt_x);
                    count_next  = count_reg + CW'(1);
                    res_next.ok = 1'b1;
                end
            end
            MODE_INSERT:
            begin
                if (!full_now && pos_x <= cnt_x)
                begin
                    ctl.op      = CELL_INSERT;
                    count_next  = count_reg + CW'(1);
                    res_next.ok = 1'b1;
                end
            end
            MODE_REMOVE_END:
            begin
                if (cnt_x != '0)
                begin
                    count_next    = count_reg - CW'(1);
                    res_next.ok   = 1'b1;
                    res_next.data = rd_data;
                end
            end
            MODE_REMOVE_POS:
            begin
                if (pos_x < cnt_x)
                begin
                    ctl.op        = CELL_REMOVE;
                    count_next    = count_reg - CW'(1);
                    res_next.ok   = 1'b1;
                    res_next.data = rd_data;
                end
            end
            MODE_READ:
            begin
                if (pos_x < cnt_x)
                begin
                    res_next.ok   = 1'b1;
                    res_next.data = rd_data;
                end
            end
            default:
            begin
                res_next.ok = 1'b0;
            end
        endcase
        if (!accept)
            ctl.op = CELL_HOLD;
        cnt_new_x          = PW'(count_next);
        res_next.count     = CAP_W'(count_next);
        res_next.empty_res = (count_next == '0);
        res_next.full_res  = cnt_new_x >= eff_cap;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_W-1:0] prev_d;
            logic [DATA_W-1:0] next_d;
            if (gi == 0)
            begin : g_first
                assign prev_d = '0;
            end
            else
            begin : g_mid_prev
                assign prev_d = cell_q[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign next_d = '0;
            end
            else
            begin : g_mid_next
                assign next_d = cell_q[gi+1];
            end
            pidl_cell #(
                .IDX (gi)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .prev_data (prev_d),
                .next_data (next_d),
                .data      (cell_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_data;
            if (accept)
                count_reg <= count_next;
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
